// ----- rtl/nmt_pkg.sv -----
// Shared types, constants and the per-mode byte decoder of the nested message tokenizer.
// Used by nested_message_tokenizer; no dependencies.
`timescale 1ns / 1ps

package nmt_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	// top of the mode stack lives in a small register cache, the rest in RAM
	localparam int CACHE_DEPTH = 8;
	localparam int CACHE_W     = $clog2(CACHE_DEPTH);
	localparam int MIN_CACHED  = 3;
	localparam int ACCEPT_MAX  = CACHE_DEPTH - 3;
	localparam int FILL_MAX    = MIN_CACHED;
	localparam int SPILL_MIN   = ACCEPT_MAX;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_W     = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_MAP_OPEN   = 8'h5B; // [
	localparam logic [7:0] CH_MAP_CLOSE  = 8'h5D; // ]
	localparam logic [7:0] CH_LIST_OPEN  = 8'h28; // (
	localparam logic [7:0] CH_LIST_CLOSE = 8'h29; // )
	localparam logic [7:0] CH_STRING     = 8'h24; // $
	localparam logic [7:0] CH_INT        = 8'h40; // @
	localparam logic [7:0] CH_FLOAT      = 8'h23; // #
	localparam logic [7:0] CH_EQUAL      = 8'h3D; // =
	localparam logic [7:0] CH_DOT        = 8'h2E; // .
	localparam logic [7:0] CH_EXP_LO     = 8'h65; // e
	localparam logic [7:0] CH_EXP_UP     = 8'h45; // E
	localparam logic [7:0] CH_MINUS      = 8'h2D; // -
	localparam logic [7:0] CH_PLUS       = 8'h2B; // +
	localparam logic [7:0] CH_ZERO       = 8'h30;
	localparam logic [7:0] CH_NINE       = 8'h39;

	typedef enum logic [3:0] {
		M_STREAM  = 4'd0,
		M_MAP     = 4'd1,
		M_LIST    = 4'd2,
		M_MAPBEG  = 4'd3,
		M_LISTBEG = 4'd4,
		M_INT     = 4'd5,
		M_FLOAT   = 4'd6,
		M_STRING  = 4'd7,
		M_NAME    = 4'd8
	} mode_t;

	typedef enum logic [3:0] {
		EV_MSG_BEGIN       = 4'd0,
		EV_MAP_END         = 4'd1,
		EV_LIST_END        = 4'd2,
		EV_LIST_MAP        = 4'd3,
		EV_LIST_LIST       = 4'd4,
		EV_NAME_BYTE       = 4'd5,
		EV_VALUE_BYTE      = 4'd6,
		EV_NAMED_MAP       = 4'd7,
		EV_NAMED_LIST      = 4'd8,
		EV_NAMED_VALUE_END = 4'd9,
		EV_LIST_VALUE_END  = 4'd10
	} ev_t;

	typedef enum logic [1:0] {
		VK_INT    = 2'd0,
		VK_FLOAT  = 2'd1,
		VK_STRING = 2'd2
	} kind_t;

	// what one mode does with one byte
	typedef struct packed {
		logic            emit;   // direct event
		logic            gated;  // event only if the push fits
		ev_t             code;
		logic [7:0]      data;
		logic            close;  // value closed, event picked by parent mode
		kind_t           kind;
		logic            pop;
		logic [1:0]      npush;
		mode_t [2:0]     pm;     // pm[0] is pushed first
		logic            again;  // parent handles the byte too
	} act_t;

	typedef struct packed {
		ev_t        code;
		kind_t      kind;
		logic [7:0] data;
		logic       last;
		logic       ovf;
	} res_t;

	function automatic logic is_term(input logic [7:0] c);
		return c == CH_MAP_OPEN || c == CH_MAP_CLOSE || c == CH_LIST_OPEN ||
			c == CH_LIST_CLOSE || c == CH_STRING || c == CH_INT || c == CH_FLOAT;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || c == CH_MINUS || c == CH_PLUS;
	endfunction

	function automatic act_t decode(input mode_t m, input logic [7:0] c);
		act_t a;
		a = '0;
		unique case (m)
			M_STREAM: begin
				if (c == CH_MAP_OPEN) begin
					a.npush = 2'd1; a.pm[0] = M_MAP;
					a.emit = 1'b1; a.gated = 1'b1; a.code = EV_MSG_BEGIN;
				end
			end
			M_MAP: begin
				if (c == CH_MAP_CLOSE) begin
					a.emit = 1'b1; a.code = EV_MAP_END; a.pop = 1'b1;
				end else if (c == CH_MAP_OPEN) begin
					a.npush = 2'd3; a.pm[0] = M_MAP; a.pm[1] = M_MAPBEG; a.pm[2] = M_NAME;
				end else if (c == CH_LIST_OPEN) begin
					a.npush = 2'd3; a.pm[0] = M_LIST; a.pm[1] = M_LISTBEG; a.pm[2] = M_NAME;
				end else if (c == CH_STRING) begin
					a.npush = 2'd2; a.pm[0] = M_STRING; a.pm[1] = M_NAME;
				end else if (c == CH_INT) begin
					a.npush = 2'd2; a.pm[0] = M_INT; a.pm[1] = M_NAME;
				end else if (c == CH_FLOAT) begin
					a.npush = 2'd2; a.pm[0] = M_FLOAT; a.pm[1] = M_NAME;
				end
			end
			M_LIST: begin
				if (c == CH_LIST_CLOSE) begin
					a.emit = 1'b1; a.code = EV_LIST_END; a.pop = 1'b1;
				end else if (c == CH_MAP_OPEN) begin
					a.npush = 2'd1; a.pm[0] = M_MAP;
					a.emit = 1'b1; a.gated = 1'b1; a.code = EV_LIST_MAP;
				end else if (c == CH_LIST_OPEN) begin
					a.npush = 2'd1; a.pm[0] = M_LIST;
					a.emit = 1'b1; a.gated = 1'b1; a.code = EV_LIST_LIST;
				end else if (c == CH_STRING) begin
					a.npush = 2'd1; a.pm[0] = M_STRING;
				end else if (c == CH_INT) begin
					a.npush = 2'd1; a.pm[0] = M_INT;
				end else if (c == CH_FLOAT) begin
					a.npush = 2'd1; a.pm[0] = M_FLOAT;
				end
			end
			M_MAPBEG: begin
				a.emit = 1'b1; a.code = EV_NAMED_MAP; a.pop = 1'b1; a.again = 1'b1;
			end
			M_LISTBEG: begin
				a.emit = 1'b1; a.code = EV_NAMED_LIST; a.pop = 1'b1; a.again = 1'b1;
			end
			M_INT: begin
				if (is_term(c)) begin
					a.close = 1'b1; a.kind = VK_INT; a.pop = 1'b1; a.again = 1'b1;
				end else if (is_digit(c)) begin
					a.emit = 1'b1; a.code = EV_VALUE_BYTE; a.data = c;
				end
			end
			M_FLOAT: begin
				if (is_term(c)) begin
					a.close = 1'b1; a.kind = VK_FLOAT; a.pop = 1'b1; a.again = 1'b1;
				end else if (is_digit(c) || c == CH_DOT || c == CH_EXP_LO || c == CH_EXP_UP) begin
					a.emit = 1'b1; a.code = EV_VALUE_BYTE; a.data = c;
				end
			end
			M_STRING: begin
				if (is_term(c)) begin
					a.close = 1'b1; a.kind = VK_STRING; a.pop = 1'b1; a.again = 1'b1;
				end else if (c != CH_EQUAL) begin
					a.emit = 1'b1; a.code = EV_VALUE_BYTE; a.data = c;
				end
			end
			M_NAME: begin
				if (c == CH_EQUAL) begin
					a.pop = 1'b1;
				end else if (!is_term(c)) begin
					a.emit = 1'b1; a.code = EV_NAME_BYTE; a.data = c;
				end
			end
			default: begin
				a = '0;
			end
		endcase
		return a;
	endfunction

endpackage

// ----- rtl/nested_message_tokenizer.sv -----
// Nested message tokenizer top level: byte register, mode stack, result queue.
// Depends on nmt_pkg and nmt_ram.
// A byte is captured in the input register, then its results go to the result queue,
// whose head drives the output. One byte per cycle while the input does not stall, one
// result out per cycle while out_stall is low. Input holds while fewer than three entries
// sit in the 8-entry top cache above RAM, more than five wait to spill, or the 4-entry
// result queue lacks two free slots. Reset: asynchronous; stack holds stream mode only.
`timescale 1ns / 1ps

module nested_message_tokenizer
	import nmt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] event_res,
	output logic [1:0] value_kind,
	output logic [7:0] data_byte,
	output logic       last,
	output logic       overflow
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// stack state
	mode_t             cache_q [CACHE_DEPTH];
	mode_t             cache_d [CACHE_DEPTH];
	logic [SP_W-1:0]   sp_q;
	logic [SP_W-1:0]   lo_q;      // lowest stack position held in the cache
	logic              pend_q;    // RAM read data arrives this cycle
	logic              ovf_q;

	// result queue
	res_t              fifo_q [FIFO_DEPTH];
	logic [FIFO_W-1:0] wr_q;
	logic [FIFO_W-1:0] rd_q;
	logic [FCNT_W-1:0] cnt_q;

	logic [SP_W-1:0]    sp_m1, sp_m2, sp_m3;
	mode_t              top0, top1, top2, mode1, close_top;
	act_t               a1, a2, act;
	logic [SP_W-1:0]    sp_h, sp_next;
	logic [SP_W:0]      push_end;
	logic               push_ok;
	logic               ovf_next;
	logic               ev_a_v, ev_b_v;
	res_t               ev_a, ev_b, first_res;
	logic [1:0]         n_wr;
	logic               adv, stack_ok, fifo_room, out_pop;
	logic [SP_W-1:0]    lo_issue, lo_dec, occ, cached;
	logic               issue, spill;
	logic [CACHE_W-1:0] push_base, fill_slot;
	logic [3:0]         ram_rd;

	assign sp_m1 = sp_q - SP_W'(1);
	assign sp_m2 = sp_q - SP_W'(2);
	assign sp_m3 = sp_q - SP_W'(3);
	assign top0  = cache_q[sp_m1[CACHE_W-1:0]];
	assign top1  = cache_q[sp_m2[CACHE_W-1:0]];
	assign top2  = cache_q[sp_m3[CACHE_W-1:0]];

	// first pass in the top mode, second pass in the parent when the byte is handed back
	always_comb begin
		a1        = decode(top0, byte_s1);
		mode1     = a1.pop ? top1 : top0;
		a2        = decode(mode1, byte_s1);
		act       = a1.again ? a2 : a1;
		sp_h      = a1.again ? (sp_q - SP_W'(a1.pop)) : sp_q;
		close_top = (a1.again && a1.pop) ? top2 : top1;
		push_end  = {1'b0, sp_h} + (SP_W + 1)'(act.npush);
		push_ok   = push_end <= (SP_W + 1)'(STACK_DEPTH);
		ovf_next  = ovf_q | ((act.npush != 2'd0) && !push_ok);
		sp_next   = sp_h - SP_W'(act.pop) + (push_ok ? SP_W'(act.npush) : SP_W'(0));
	end

	// events of the two passes
	always_comb begin
		ev_a      = '0;
		ev_a_v    = 1'b0;
		ev_a.ovf  = ovf_next;
		if (a1.again) begin
			if (a1.close) begin
				ev_a_v    = (mode1 == M_MAP) || (mode1 == M_LIST);
				ev_a.code = (mode1 == M_MAP) ? EV_NAMED_VALUE_END : EV_LIST_VALUE_END;
				ev_a.kind = a1.kind;
			end else begin
				ev_a_v    = a1.emit;
				ev_a.code = a1.code;
				ev_a.data = a1.data;
			end
		end

		ev_b      = '0;
		ev_b.ovf  = ovf_next;
		ev_b.last = 1'b1;
		if (act.close) begin
			ev_b_v    = (close_top == M_MAP) || (close_top == M_LIST);
			ev_b.code = (close_top == M_MAP) ? EV_NAMED_VALUE_END : EV_LIST_VALUE_END;
			ev_b.kind = act.kind;
		end else begin
			ev_b_v    = act.emit && (!act.gated || push_ok);
			ev_b.code = act.code;
			ev_b.data = act.data;
		end

		n_wr           = 2'(ev_a_v) + 2'(ev_b_v);
		first_res      = ev_a_v ? ev_a : ev_b;
		first_res.last = (n_wr == 2'd1);
	end

	// cache occupancy and RAM spill / refill
	assign lo_issue  = lo_q - SP_W'(pend_q);
	assign lo_dec    = lo_issue - SP_W'(1);
	assign occ       = sp_q - lo_issue;
	assign cached    = sp_q - lo_q;
	assign issue     = (lo_issue != '0) && (occ <= SP_W'(FILL_MAX));
	assign spill     = !pend_q && (occ >= SP_W'(SPILL_MIN));
	assign stack_ok  = ((lo_q == '0) || (cached >= SP_W'(MIN_CACHED))) &&
		(occ <= SP_W'(ACCEPT_MAX));
	assign fifo_room = cnt_q <= FCNT_W'(FIFO_DEPTH - 2);
	assign adv       = valid_s1 && stack_ok && fifo_room;
	assign in_stall  = valid_s1 && !adv;
	assign push_base = sp_h[CACHE_W-1:0];
	assign fill_slot = CACHE_W'(lo_q - SP_W'(1));

	nmt_ram #(
		.WIDTH (4),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk     (clk),
		.wr_en   (spill),
		.wr_addr (lo_q[ADDR_W-1:0]),
		.wr_data (cache_q[lo_q[CACHE_W-1:0]]),
		.rd_en   (issue),
		.rd_addr (lo_dec[ADDR_W-1:0]),
		.rd_data (ram_rd)
	);

	always_comb begin
		for (int j = 0; j < CACHE_DEPTH; j++) begin
			cache_d[j] = cache_q[j];
		end
		if (pend_q) begin
			cache_d[fill_slot] = mode_t'(ram_rd);
		end
		if (adv && push_ok) begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < act.npush) begin
					cache_d[push_base + CACHE_W'(i)] = act.pm[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < CACHE_DEPTH; j++) begin
				cache_q[j] <= M_STREAM;
			end
			sp_q   <= SP_W'(1);
			lo_q   <= '0;
			pend_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else begin
			for (int j = 0; j < CACHE_DEPTH; j++) begin
				cache_q[j] <= cache_d[j];
			end
			pend_q <= issue;
			if (pend_q) begin
				lo_q <= lo_q - SP_W'(1);
			end else if (spill) begin
				lo_q <= lo_q + SP_W'(1);
			end
			if (adv) begin
				sp_q  <= sp_next;
				ovf_q <= ovf_next;
			end
		end
	end

	// input register: hold while the stage cannot advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// result queue
	assign out_valid = cnt_q != '0;
	assign out_pop   = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (adv) begin
				wr_q <= wr_q + FIFO_W'(n_wr);
			end
			if (out_pop) begin
				rd_q <= rd_q + FIFO_W'(1);
			end
			cnt_q <= cnt_q + (adv ? FCNT_W'(n_wr) : FCNT_W'(0)) - FCNT_W'(out_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && n_wr != 2'd0) begin
			fifo_q[wr_q] <= first_res;
		end
		if (adv && n_wr == 2'd2) begin
			fifo_q[wr_q + FIFO_W'(1)] <= ev_b;
		end
	end

	assign event_res  = fifo_q[rd_q].code;
	assign value_kind = fifo_q[rd_q].kind;
	assign data_byte  = fifo_q[rd_q].data;
	assign last       = fifo_q[rd_q].last;
	assign overflow   = fifo_q[rd_q].ovf;

endmodule

// ----- rtl/nmt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the lower part of the tokenizer mode stack.
`timescale 1ns / 1ps

module nmt_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
